// ----- src/pixelate_2x2_block_average_top_macros.svh -----
`ifndef PIXELATE_2X2_BLOCK_AVERAGE_TOP_MACROS_SVH
`define PIXELATE_2X2_BLOCK_AVERAGE_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define P2_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition never occurs.
`define P2_NEVER(label, cond, msg) \
  `P2_CHECK(label, 1'b1, !(cond), msg)

`endif

// ----- src/pix2x2_pkg.sv -----
package pix2x2_pkg;

  // Configuration register file.
  localparam int CFG_W = 11;
  typedef logic [0:0] reg_index_t;
  localparam reg_index_t REG_IMAGE_WIDTH  = 1'd0;
  localparam reg_index_t REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // Payload widths.
  localparam int PIX_W = 8;
  localparam int PAIR_W = PIX_W + 1;
  localparam int SUM_W = PIX_W + 2;
  localparam int OUT_W = 10;

  // Block queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;

  // Position of the bottom-right result within a block.
  localparam logic [1:0] SUB_LAST = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] column;
    logic [PIX_W-1:0] average;
  } block_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- src/pix2x2_if.sv -----
interface pixel_if;
  logic                        valid;
  logic                        ready;
  logic [pix2x2_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface result_if;
  logic                        valid;
  logic                        ready;
  logic [pix2x2_pkg::OUT_W-1:0] out_row;
  logic [pix2x2_pkg::OUT_W-1:0] out_column;
  logic [pix2x2_pkg::PIX_W-1:0] block_average;
  logic                        block_last;

  modport source (output valid, output out_row, output out_column,
                  output block_average, output block_last, input ready);
  modport sink (input valid, input out_row, input out_column,
                input block_average, input block_last, output ready);
endinterface

// ----- src/pixelate_2x2_block_average_top.sv -----
// 2x2 box-average pixelation of a raster-order 8-bit greyscale stream. Write
// the image width (register 0) and height (register 1) while the block is
// idle; values outside 2..MAX_WIDTH or 2..MAX_HEIGHT are saturated. Each
// aligned 2x2 block is replaced by its mean rounded half up, and when the
// bottom-right pixel of a block arrives four result transactions follow, in
// the order top-left, top-right, bottom-left, bottom-right, with the fourth
// flagged by block_last. An odd trailing row or column is consumed without
// results. The input takes one pixel per cycle while the block queue is not
// full; the line store is read when the left pixel of a pair arrives, so no
// pixel waits on the memory. The output register issues one result per cycle
// while the output is ready, so in odd rows the stream of four results per two
// pixels sets the pace, the four-entry block queue absorbing short bursts,
// while even rows take one pixel per cycle unless the queue is full.
// There is no clearing pass after reset: the line store is always written in
// an even row before it is read in the odd row below.

`include "pixelate_2x2_block_average_top_macros.svh"

module pixelate_2x2_block_average_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  pix2x2_pkg::reg_index_t        cfg_index,
  input  logic [pix2x2_pkg::CFG_W-1:0]  cfg_data,
  pixel_if.sink                         pix_in,
  result_if.source                      res_out
);

  import pix2x2_pkg::*;

  // Blocks found by the front end, waiting to be expanded into results.
  logic        push;
  logic        pop;
  block_t      push_block;
  block_t      head;
  queue_stat_t queue_stat;

  // The front end counts columns and rows, keeps the line of top-row pair
  // sums and forms the rounded average when a block completes.
  pix2x2_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_in     (pix_in),
    .queue_stat (queue_stat),
    .push       (push),
    .push_block (push_block)
  );

  // The queue lets the input keep flowing while the output stalls.
  pix2x2_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_block (push_block),
    .pop        (pop),
    .head       (head),
    .stat       (queue_stat)
  );

  // The back end turns each block into its four result transactions.
  pix2x2_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .queue_stat (queue_stat),
    .pop        (pop),
    .res_out    (res_out)
  );

  // Shorthands for the checks below: a result that is not the last of its
  // block, the last result of a block, and an odd row and column position.
  logic out_mid;
  logic out_last;
  logic last_odd;

  assign out_mid  = res_out.valid && !res_out.block_last;
  assign out_last = res_out.valid && res_out.block_last;
  assign last_odd = res_out.out_row[0] && res_out.out_column[0];

  // A block must never be offered to a full queue.
  `P2_NEVER(a_no_push_when_full, push && queue_stat.full, "block pushed into a full queue")

  // Until its fourth result is loaded, a block stays at the head of the queue.
  `P2_CHECK(a_block_held, out_mid, !queue_stat.empty, "block left queue early")

  // The fourth result of a block sits on odd row and column.
  `P2_CHECK(a_last_position, out_last, last_odd, "last result misplaced")

endmodule

// ----- src/pix2x2_ram.sv -----
module pix2x2_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pix2x2_front.sv -----
module pix2x2_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  pix2x2_pkg::reg_index_t        cfg_index,
  input  logic [pix2x2_pkg::CFG_W-1:0]  cfg_data,
  pixel_if.sink                         pix_in,
  input  pix2x2_pkg::queue_stat_t       queue_stat,
  output logic                          push,
  output pix2x2_pkg::block_t            push_block
);

  import pix2x2_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = $clog2(MAX_WIDTH + 1);
  localparam int SH = $clog2(MAX_HEIGHT + 1);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;
  logic [PIX_W-1:0] left_pixel;

  logic [SW-1:0]    w;
  logic [SH-1:0]    h;
  logic [SW-1:0]    wlim;
  logic [SH-1:0]    hlim;
  logic             accept;
  logic             col_odd;
  logic             row_odd;
  logic             in_cols;
  logic             in_rows;
  logic [PAIR_W-1:0] pair;
  logic [PAIR_W-1:0] top_pair;
  logic [SUM_W-1:0]  sum_rnd;
  logic [CW:0]      col_inc;
  logic [RW:0]      row_inc;
  logic [OUT_W-1:0] row_out;
  logic [OUT_W-1:0] col_out;
  logic             line_we;
  logic             line_re;
  logic [AW-1:0]    line_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes in use are saturated to the supported range.
  always_comb begin
    if (image_width < CFG_W'(2)) begin
      w = SW'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = SW'(MAX_WIDTH);
    end else begin
      w = SW'(image_width);
    end
    if (image_height < CFG_W'(2)) begin
      h = SH'(2);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = SH'(MAX_HEIGHT);
    end else begin
      h = SH'(image_height);
    end
  end

  assign wlim = {w[SW-1:1], 1'b0};
  assign hlim = {h[SH-1:1], 1'b0};

  assign pix_in.ready = !queue_stat.full;
  assign accept  = pix_in.valid && pix_in.ready;
  assign col_odd = column_count[0];
  assign row_odd = row_count[0];
  assign in_cols = 32'(column_count) < 32'(wlim);
  assign in_rows = 32'(row_count) < 32'(hlim);

  assign pair = PAIR_W'(left_pixel) + PAIR_W'(pix_in.pixel_value);

  // The line entry for a pair is fetched when its left pixel arrives, so the
  // registered read data is ready for the right pixel.
  assign line_addr = AW'(column_count >> 1);
  assign line_re   = accept && !col_odd;
  assign line_we   = accept && col_odd && in_cols && !row_odd;

  pix2x2_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (pair),
    .re    (line_re),
    .raddr (line_addr),
    .rdata (top_pair)
  );

  assign sum_rnd = SUM_W'(top_pair) + SUM_W'(pair) + SUM_W'(2);
  assign row_out = OUT_W'(row_count);
  assign col_out = OUT_W'(column_count);

  assign push = accept && col_odd && in_cols && row_odd && in_rows;
  assign push_block.row     = {row_out[OUT_W-1:1], 1'b0};
  assign push_block.column  = {col_out[OUT_W-1:1], 1'b0};
  assign push_block.average = sum_rnd[SUM_W-1:2];

  assign col_inc = {1'b0, column_count} + (CW+1)'(1);
  assign row_inc = {1'b0, row_count} + (RW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (32'(col_inc) >= 32'(w)) begin
        column_count <= '0;
        if (32'(row_inc) >= 32'(h)) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[RW-1:0];
        end
      end else begin
        column_count <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (line_re) begin
      left_pixel <= pix_in.pixel_value;
    end
  end

endmodule

// ----- src/pix2x2_queue.sv -----
module pix2x2_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  pix2x2_pkg::block_t          push_block,
  input  logic                        pop,
  output pix2x2_pkg::block_t          head,
  output pix2x2_pkg::queue_stat_t     stat
);

  import pix2x2_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  block_t        entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign stat.full  = count == NW'(QUEUE_DEPTH);
  assign stat.empty = count == '0;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_block;
    end
  end

endmodule

// ----- src/pix2x2_back.sv -----
module pix2x2_back (
  input  logic                     clk,
  input  logic                     rst,
  input  pix2x2_pkg::block_t       head,
  input  pix2x2_pkg::queue_stat_t  queue_stat,
  output logic                     pop,
  result_if.source                 res_out
);

  import pix2x2_pkg::*;

  logic [1:0] sub;
  logic       load;

  // A block leaves the queue when its fourth result enters the output register.
  assign load = !queue_stat.empty && (!res_out.valid || res_out.ready);
  assign pop  = load && (sub == SUB_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub           <= '0;
      res_out.valid <= 1'b0;
    end else if (load) begin
      sub           <= sub + 2'd1;
      res_out.valid <= 1'b1;
    end else if (res_out.ready) begin
      res_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out.out_row       <= head.row | OUT_W'(sub[1]);
      res_out.out_column    <= head.column | OUT_W'(sub[0]);
      res_out.block_average <= head.average;
      res_out.block_last    <= sub == SUB_LAST;
    end
  end

endmodule
